// ===== sv/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int MEM_CELLS    = 8192;
    localparam int SCREEN_CELLS = COLS * ROWS;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CELL_W = $clog2(MEM_CELLS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SCR_W  = $clog2(SCREEN_CELLS);
    localparam int CHK_W  = $clog2(MEM_CELLS + SCREEN_CELLS + COLS);
    localparam int QP_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CELL_W-1:0] COLS_CELLS = CELL_W'(COLS);
    localparam logic [CELL_W-1:0] SCREEN_MOD = CELL_W'(SCREEN_CELLS % MEM_CELLS);

    localparam logic [15:0] BLANK_CELL      = 16'h0720;
    localparam logic [7:0]  CHAR_ATTR_RESET = 8'h07;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DEL = 8'h7F;

    typedef enum logic [3:0] {
        OP_READ,
        OP_NOP,
        OP_BEEP,
        OP_BS,
        OP_LF,
        OP_FF,
        OP_CR,
        OP_DEL,
        OP_PRINT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        char_byte;
        logic              last_of_write;
        logic [CELL_W-1:0] read_cell;
    } t_cmd;

    typedef struct packed {
        logic [CELL_W-1:0] hw_cursor_cell;
        logic [CELL_W-1:0] window_start_cell;
        logic              beep_pulse;
        logic [15:0]       read_data;
    } t_out_item;

    function automatic logic [CELL_W-1:0] wrap_add(input logic [CELL_W-1:0] a,
                                                   input logic [CELL_W-1:0] d);
        logic [CELL_W:0] s;
        s = {1'b0, a} + {1'b0, d};
        if (s >= (CELL_W+1)'(MEM_CELLS)) begin
            s = s - (CELL_W+1)'(MEM_CELLS);
        end
        return s[CELL_W-1:0];
    endfunction

    function automatic logic [CELL_W-1:0] wrap_sub(input logic [CELL_W-1:0] a,
                                                   input logic [CELL_W-1:0] d);
        logic [CELL_W-1:0] r;
        if (a >= d) begin
            r = a - d;
        end else begin
            r = a + CELL_W'(MEM_CELLS) - d;
        end
        return r;
    endfunction

endpackage

// ===== sv/tccw_if.sv =====
`timescale 1ns / 1ps

interface tccw_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [7:0]                     char_byte;
    logic                           last_of_write;
    logic [tccw_pkg::CELL_W-1:0]    read_cell;

    modport source (output valid, mode, char_byte, last_of_write, read_cell, input ready);
    modport sink   (input valid, mode, char_byte, last_of_write, read_cell, output ready);
endinterface

interface tccw_out_if;
    logic                           valid;
    logic                           ready;
    logic [tccw_pkg::CELL_W-1:0]    hw_cursor_cell;
    logic [tccw_pkg::CELL_W-1:0]    window_start_cell;
    logic                           beep_pulse;
    logic [15:0]                    read_data;

    modport source (output valid, hw_cursor_cell, window_start_cell, beep_pulse, read_data,
                    input ready);
    modport sink   (input valid, hw_cursor_cell, window_start_cell, beep_pulse, read_data,
                    output ready);
endinterface

interface tccw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_attribute;

    modport source (output valid, char_attribute, input ready);
    modport sink   (input valid, char_attribute, output ready);
endinterface

// ===== sv/text_console_char_writer.sv =====
`timescale 1ns / 1ps

// Text console writer over an 8192-cell character memory, 80x25 visible window.
// i_item: one item per byte (mode 0) or per cell read (mode 1), valid/ready.
// o_result: exactly one item per input item, in order, valid/ready; it carries the
//   hardware cursor, the window start, a beep flag and the read cell (0 on writes).
// i_cfg: attribute byte, always ready, to be written while the block is idle.
// Input items are decoded into a two-entry queue; the executor pops one when its
// output register is free or being emptied, so the two sides stall independently.
// Results pass the queue slot and the output register; a read also passes the
// registered memory read. One write byte per cycle while the receiver is ready;
// a read ends before the next item is taken. A line feed on the last row scrolls:
// S_BLANK blanks an 80-cell row, then S_FINISH emits; when the window nears the
// end of memory a 2000-cell copy comes first, paced by the single read and write port.
// After reset a sweep blanks all 8192 cells, one per cycle; no item is accepted
// until it ends. A stalled receiver holds the result and backs up the queue.
module text_console_char_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tccw_in_if.sink     i_item,
    tccw_out_if.source  o_result,
    tccw_cfg_if.sink    i_cfg
);
    import tccw_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    logic clearing;

    tccw_front u_front (
        .i_item     (i_item),
        .i_clearing (clearing),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    tccw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_clearing  (clearing),
        .o_result    (o_result),
        .i_cfg       (i_cfg)
    );

endmodule

// ===== sv/tccw_front.sv =====
`timescale 1ns / 1ps

module tccw_front (
    tccw_in_if.sink         i_item,
    input  logic            i_clearing,
    input  logic            i_q_ready,
    output logic            o_push,
    output tccw_pkg::t_cmd  o_cmd
);
    import tccw_pkg::*;

    t_op op;

    always_comb begin
        if (i_item.mode) begin
            op = OP_READ;
        end else begin
            case (i_item.char_byte)
                CH_NUL, CH_ENQ, CH_HT, CH_VT: op = OP_NOP;
                CH_BEL:  op = OP_BEEP;
                CH_BS:   op = OP_BS;
                CH_LF:   op = OP_LF;
                CH_FF:   op = OP_FF;
                CH_CR:   op = OP_CR;
                CH_DEL:  op = OP_DEL;
                default: op = OP_PRINT;
            endcase
        end
    end

    // nothing enters while the memory sweep after reset runs
    assign i_item.ready = i_q_ready && !i_clearing;
    assign o_push       = i_item.valid && i_item.ready;

    assign o_cmd.op            = op;
    assign o_cmd.char_byte     = i_item.char_byte;
    assign o_cmd.last_of_write = i_item.last_of_write;
    assign o_cmd.read_cell     = i_item.read_cell;

endmodule

// ===== sv/tccw_queue.sv =====
`timescale 1ns / 1ps

module tccw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tccw_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output tccw_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import tccw_pkg::*;

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_ready = r_count < QC_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/tccw_back.sv =====
`timescale 1ns / 1ps

module tccw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  tccw_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_clearing,
    tccw_out_if.source      o_result,
    tccw_cfg_if.sink        i_cfg
);
    import tccw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COPY,
        S_COPY_END,
        S_BLANK,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [CELL_W-1:0] r_ws, n_ws;
    logic [CELL_W-1:0] r_cell, n_cell;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CELL_W-1:0] r_shown, n_shown;
    logic [7:0]        r_attr, n_attr;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    t_cmd              r_cmd, n_cmd;
    logic [CELL_W-1:0] r_src, n_src;
    logic [CELL_W-1:0] r_dst, n_dst;
    logic [SCR_W-1:0]  r_cnt, n_cnt;
    logic              r_cp_wv, n_cp_wv;

    logic [15:0]       r_mem [MEM_CELLS];
    logic [15:0]       r_rd_data;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [CELL_W-1:0] mem_raddr;

    logic              out_free;

    assign out_free       = !r_out_valid || o_result.ready;
    assign o_clearing     = (r_state == S_CLEAR);
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid             = r_out_valid;
    assign o_result.hw_cursor_cell    = r_out.hw_cursor_cell;
    assign o_result.window_start_cell = r_out.window_start_cell;
    assign o_result.beep_pulse        = r_out.beep_pulse;
    assign o_result.read_data         = r_out.read_data;

    always_comb begin
        logic              v_emit;
        logic              v_last;
        logic              v_beep;
        logic [15:0]       v_rdata;
        logic              v_wrap;
        logic              v_last_row;
        logic              v_scroll;
        logic [CELL_W-1:0] v_cell;
        logic [COL_W-1:0]  v_col;
        logic [CHK_W-1:0]  v_sum;

        n_state     = r_state;
        n_ws        = r_ws;
        n_cell      = r_cell;
        n_col       = r_col;
        n_row       = r_row;
        n_shown     = r_shown;
        n_attr      = i_cfg.valid ? i_cfg.char_attribute : r_attr;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;
        n_cmd       = r_cmd;
        n_src       = r_src;
        n_dst       = r_dst;
        n_cnt       = r_cnt;
        n_cp_wv     = 1'b0;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_dst;
        mem_wdata   = BLANK_CELL;
        mem_raddr   = r_src;

        v_emit     = 1'b0;
        v_last     = 1'b0;
        v_beep     = 1'b0;
        v_rdata    = '0;
        v_wrap     = r_col >= COL_W'(COLS);
        v_last_row = r_row == ROW_W'(ROWS - 1);
        v_scroll   = 1'b0;
        v_cell     = r_cell;
        v_col      = r_col;
        v_sum      = CHK_W'(r_ws) + CHK_W'(SCREEN_CELLS + COLS);

        // copy write comes in the cycle after its read
        if (r_cp_wv) begin
            mem_we    = 1'b1;
            mem_waddr = r_dst;
            mem_wdata = r_rd_data;
            n_dst     = wrap_add(r_dst, CELL_W'(1));
        end

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_dst;
                mem_wdata = BLANK_CELL;
                if (r_dst == CELL_W'(MEM_CELLS - 1)) begin
                    n_dst   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_dst = r_dst + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    v_last    = i_cmd.last_of_write;
                    case (i_cmd.op)
                        OP_READ: begin
                            mem_raddr = i_cmd.read_cell;
                            n_state   = S_READ;
                        end
                        OP_NOP: begin
                            v_emit = 1'b1;
                        end
                        OP_BEEP: begin
                            v_emit = 1'b1;
                            v_beep = 1'b1;
                        end
                        OP_BS: begin
                            v_emit = 1'b1;
                            if (r_col != '0) begin
                                v_cell    = wrap_sub(r_cell, CELL_W'(1));
                                n_cell    = v_cell;
                                n_col     = r_col - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = v_cell;
                                mem_wdata = BLANK_CELL;
                            end
                        end
                        OP_LF: begin
                            if (v_last_row) begin
                                v_scroll = 1'b1;
                            end else begin
                                v_emit = 1'b1;
                                n_row  = r_row + 1'b1;
                                n_cell = wrap_sub(wrap_add(r_cell, COLS_CELLS), CELL_W'(r_col));
                                n_col  = '0;
                            end
                        end
                        OP_FF: begin
                            if (v_last_row) begin
                                v_scroll = 1'b1;
                            end else begin
                                v_emit = 1'b1;
                                n_row  = r_row + 1'b1;
                                n_cell = wrap_add(r_cell, COLS_CELLS);
                            end
                        end
                        OP_CR: begin
                            v_emit = 1'b1;
                            n_cell = wrap_sub(r_cell, CELL_W'(r_col));
                            n_col  = '0;
                        end
                        OP_DEL: begin
                            v_emit    = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = r_cell;
                            mem_wdata = BLANK_CELL;
                        end
                        OP_PRINT: begin
                            if (v_wrap && v_last_row) begin
                                // wrap on the last row: scroll first, store afterwards
                                v_scroll = 1'b1;
                                v_cell   = wrap_sub(r_cell, COLS_CELLS);
                                n_col    = r_col - COL_W'(COLS);
                            end else begin
                                v_emit = 1'b1;
                                if (v_wrap) begin
                                    v_col = r_col - COL_W'(COLS);
                                    n_row = r_row + 1'b1;
                                end
                                mem_we    = 1'b1;
                                mem_waddr = r_cell;
                                mem_wdata = {r_attr, i_cmd.char_byte};
                                n_cell    = wrap_add(r_cell, CELL_W'(1));
                                n_col     = v_col + 1'b1;
                            end
                        end
                        default: begin
                            v_emit = 1'b1;
                        end
                    endcase
                    if (v_scroll) begin
                        n_cnt = '0;
                        if (v_sum >= CHK_W'(MEM_CELLS)) begin
                            // move the visible screen back to cell 0 first
                            n_cell  = wrap_sub(v_cell, r_ws);
                            n_src   = r_ws;
                            n_dst   = '0;
                            n_state = S_COPY;
                        end else begin
                            n_cell  = v_cell;
                            n_dst   = wrap_add(r_ws, SCREEN_MOD);
                            n_state = S_BLANK;
                        end
                    end
                end
            end
            S_READ: begin
                v_emit  = 1'b1;
                v_rdata = r_rd_data;
                n_state = S_IDLE;
            end
            S_COPY: begin
                mem_raddr = r_src;
                n_src     = wrap_add(r_src, CELL_W'(1));
                n_cp_wv   = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == SCR_W'(SCREEN_CELLS - 1)) begin
                    n_state = S_COPY_END;
                end
            end
            S_COPY_END: begin
                n_ws    = '0;
                n_dst   = SCREEN_MOD;
                n_cnt   = '0;
                n_state = S_BLANK;
            end
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_dst;
                mem_wdata = BLANK_CELL;
                n_dst     = wrap_add(r_dst, CELL_W'(1));
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == SCR_W'(COLS - 1)) begin
                    n_ws    = wrap_add(r_ws, COLS_CELLS);
                    n_cell  = wrap_add(r_cell, COLS_CELLS);
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                v_emit  = 1'b1;
                v_last  = r_cmd.last_of_write;
                n_state = S_IDLE;
                case (r_cmd.op)
                    OP_LF: begin
                        n_cell = wrap_sub(r_cell, CELL_W'(r_col));
                        n_col  = '0;
                    end
                    OP_PRINT: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cell;
                        mem_wdata = {r_attr, r_cmd.char_byte};
                        n_cell    = wrap_add(r_cell, CELL_W'(1));
                        n_col     = r_col + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (v_emit) begin
            if (v_last) begin
                n_shown = n_cell;
            end
            n_out_valid             = 1'b1;
            n_out.hw_cursor_cell    = n_shown;
            n_out.window_start_cell = n_ws;
            n_out.beep_pulse        = v_beep;
            n_out.read_data         = v_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ws        <= '0;
            r_cell      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_shown     <= '0;
            r_attr      <= CHAR_ATTR_RESET;
            r_out_valid <= 1'b0;
            r_dst       <= '0;
            r_cnt       <= '0;
            r_cp_wv     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ws        <= n_ws;
            r_cell      <= n_cell;
            r_col       <= n_col;
            r_row       <= n_row;
            r_shown     <= n_shown;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
            r_cmd       <= n_cmd;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_cnt       <= n_cnt;
            r_cp_wv     <= n_cp_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (!r_out_valid || o_result.ready))
        else $error("item taken from queue with result slot occupied");

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cmd_pop)
        else $error("item taken during memory sweep");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_out_valid)
        else $error("read item gave no result");

    a_window_moves_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_ws) |-> ($past(r_state) == S_COPY_END || $past(r_state) == S_BLANK))
        else $error("window start moved outside a scroll");

endmodule
